/* hw/rtl/tdl_pkg.sv */
// Shared types, codes and helpers for the template delimiter lexer.
// Used by tdl_front, tdl_queue, tdl_back, the top level and its checker.
package tdl_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int LINE_OUT_W  = 16;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    localparam logic [2:0] K_CBYTE  = 3'd0;
    localparam logic [2:0] K_IBYTE  = 3'd1;
    localparam logic [2:0] K_CEND   = 3'd2;
    localparam logic [2:0] K_IEND   = 3'd3;
    localparam logic [2:0] K_EOPEN  = 3'd4;
    localparam logic [2:0] K_ECLOSE = 3'd5;
    localparam logic [2:0] K_BOPEN  = 3'd6;
    localparam logic [2:0] K_BCLOSE = 3'd7;

    // lexer modes
    localparam logic [1:0] MODE_OUTSIDE = 2'd0;
    localparam logic [1:0] MODE_EXPR    = 2'd1;
    localparam logic [1:0] MODE_BLOCK   = 2'd2;

    // delimiter bytes
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            data;
        logic [LINE_OUT_W-1:0] line;
        logic [LEN_OUT_W-1:0]  length;
    } tdl_result_t;

    typedef struct packed {
        logic [CNT_W-1:0]                    cnt;
        tdl_result_t [MAX_RESULTS-1:0]       res;
    } tdl_bundle_t;

    typedef struct packed {
        logic        valid;
        tdl_bundle_t bundle;
    } tdl_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tdl_qstat_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [7:0]             hb;
        logic                   hv;
        logic [LINE_BITS-1:0]   line;
        logic [LENGTH_BITS-1:0] run;
    } tdl_state_t;

    function automatic logic [LEN_OUT_W-1:0] sat_len(input logic [LENGTH_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'({LEN_OUT_W{1'b1}}))
            return '1;
        return w[LEN_OUT_W-1:0];
    endfunction

    function automatic logic [LINE_OUT_W-1:0] cut_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[LINE_OUT_W-1:0];
    endfunction

    function automatic tdl_result_t make_result(input logic [2:0]             kind,
                                                input logic [7:0]             data,
                                                input logic [LINE_BITS-1:0]   line,
                                                input logic [LENGTH_BITS-1:0] run);
        tdl_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.line   = cut_line(line);
        r.length = sat_len(run);
        return r;
    endfunction

endpackage

/* hw/rtl/tdl_front.sv */
// Front end: accepts text bytes, keeps the lexer state and builds the
// bundle of results that each byte causes. Depends on tdl_pkg.
module tdl_front
    import tdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] byte_value,
    input  logic       end_of_text,
    input  tdl_qstat_t qstat,
    output tdl_push_t  push
);

    typedef struct packed {
        tdl_state_t  st;
        logic        fire;
        tdl_result_t res;
    } tdl_plain_t;

    tdl_state_t  state_reg;
    tdl_state_t  state_next;
    tdl_bundle_t bundle_next;
    logic        accept;

    function automatic tdl_plain_t plain_step(input tdl_state_t st, input logic [7:0] b);
        tdl_plain_t p;
        p.st   = st;
        p.fire = 1'b0;
        p.res  = '0;
        if (st.mode == MODE_EXPR || st.mode == MODE_BLOCK)
        begin
            if (b == CH_SPACE)
            begin
                if (st.run != '0)
                begin
                    p.fire = 1'b1;
                    p.res  = make_result(K_IEND, 8'd0, st.line, st.run);
                end
                p.st.run = '0;
            end
            else
            begin
                if (st.run != '1)
                    p.st.run = st.run + LENGTH_BITS'(1);
                p.fire = 1'b1;
                p.res  = make_result(K_IBYTE, b, st.line, '0);
            end
        end
        else
        begin
            // count the newline before its own result
            if (b == CH_NEWLINE)
                p.st.line = st.line + LINE_BITS'(1);
            if (st.run != '1)
                p.st.run = st.run + LENGTH_BITS'(1);
            p.fire = 1'b1;
            p.res  = make_result(K_CBYTE, b, p.st.line, '0);
        end
        return p;
    endfunction

    always_comb
    begin : p_lex
        tdl_state_t  s;
        tdl_bundle_t bnd;
        tdl_plain_t  p;
        logic [CNT_W-1:0] n;
        logic        tag;

        s   = state_reg;
        bnd = '0;
        n   = '0;
        p   = '0;
        tag = (s.mode == MODE_EXPR || s.mode == MODE_BLOCK);

        if (!s.hv)
        begin
            s.hb = byte_value;
            s.hv = 1'b1;
        end
        else if (!tag && s.hb == CH_LBRACE &&
                 (byte_value == CH_LBRACE || byte_value == CH_PERCENT))
        begin
            if (s.run != '0)
            begin
                bnd.res[n[IDX_W-1:0]] = make_result(K_CEND, 8'd0, s.line, s.run);
                n = n + CNT_W'(1);
            end
            s.run = '0;
            bnd.res[n[IDX_W-1:0]] = make_result((byte_value == CH_LBRACE) ? K_EOPEN : K_BOPEN,
                                                8'd0, s.line, '0);
            n      = n + CNT_W'(1);
            s.mode = (byte_value == CH_LBRACE) ? MODE_EXPR : MODE_BLOCK;
            s.hv   = 1'b0;
            s.hb   = '0;
        end
        else if (tag && (s.hb == CH_RBRACE || s.hb == CH_PERCENT) &&
                 byte_value == CH_RBRACE)
        begin
            // flush a pending identifier before the close
            if (s.run != '0)
            begin
                bnd.res[n[IDX_W-1:0]] = make_result(K_IEND, 8'd0, s.line, s.run);
                n = n + CNT_W'(1);
            end
            s.run = '0;
            bnd.res[n[IDX_W-1:0]] = make_result((s.hb == CH_RBRACE) ? K_ECLOSE : K_BCLOSE,
                                                8'd0, s.line, '0);
            n      = n + CNT_W'(1);
            s.mode = MODE_OUTSIDE;
            s.hv   = 1'b0;
            s.hb   = '0;
        end
        else
        begin
            p = plain_step(s, s.hb);
            s = p.st;
            if (p.fire)
            begin
                bnd.res[n[IDX_W-1:0]] = p.res;
                n = n + CNT_W'(1);
            end
            s.hb = byte_value;
        end

        if (end_of_text)
        begin
            if (s.hv)
            begin
                p = plain_step(s, s.hb);
                s = p.st;
                if (p.fire)
                begin
                    bnd.res[n[IDX_W-1:0]] = p.res;
                    n = n + CNT_W'(1);
                end
            end
            tag = (s.mode == MODE_EXPR || s.mode == MODE_BLOCK);
            if (tag)
            begin
                if (s.run != '0)
                begin
                    bnd.res[n[IDX_W-1:0]] = make_result(K_IEND, 8'd0, s.line, s.run);
                    n = n + CNT_W'(1);
                end
                bnd.res[n[IDX_W-1:0]] = make_result(K_BCLOSE, 8'd0, s.line, '0);
                n = n + CNT_W'(1);
            end
            else if (s.run != '0)
            begin
                bnd.res[n[IDX_W-1:0]] = make_result(K_CEND, 8'd0, s.line, s.run);
                n = n + CNT_W'(1);
            end
            // start the next text fresh
            s = '0;
        end

        bnd.cnt     = n;
        state_next  = s;
        bundle_next = bnd;
    end

    assign item_ready  = !qstat.full;
    assign accept      = item_valid && item_ready;
    assign push.valid  = accept && (bundle_next.cnt != '0);
    assign push.bundle = bundle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/tdl_queue.sv */
// Short queue of result bundles between the front and back ends.
// Depends on tdl_pkg.
module tdl_queue
    import tdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tdl_push_t   push,
    input  logic        pop,
    output tdl_bundle_t head,
    output tdl_qstat_t  qstat
);

    tdl_bundle_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* hw/rtl/tdl_back.sv */
// Back end: takes bundles from the queue and hands out their results one beat
// per cycle while result_ready is high, from a holding register. Depends on tdl_pkg.
module tdl_back
    import tdl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdl_bundle_t           head,
    input  tdl_qstat_t            qstat,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [2:0]            kind,
    output logic [7:0]            out_byte,
    output logic [LINE_OUT_W-1:0] line_number,
    output logic [LEN_OUT_W-1:0]  token_length,
    output logic                  last_of_run
);

    tdl_bundle_t      cur_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic             fire;
    logic             is_last;
    tdl_result_t      sel;

    assign sel          = cur_reg.res[idx_reg];
    assign is_last      = (CNT_W'(idx_reg) == cur_reg.cnt - CNT_W'(1));
    assign fire         = valid_reg && result_ready;
    // load the next bundle when empty or when the last beat goes out
    assign pop          = !qstat.empty && (!valid_reg || (fire && is_last));

    assign result_valid = valid_reg;
    assign kind         = sel.kind;
    assign out_byte     = sel.data;
    assign line_number  = sel.line;
    assign token_length = sel.length;
    assign last_of_run  = is_last;

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

endmodule

/* hw/rtl/template_delimiter_lexer.sv */
// Template delimiter lexer, top level.
// Input channel item_valid/item_ready carries one text byte per beat
// (byte_value, end_of_text marks the final byte). Output channel
// result_valid/result_ready carries token results (kind, out_byte,
// line_number, token_length, last_of_run); one input byte causes zero to
// four results, and last_of_run flags the final one of each group.
// The front end decodes a byte and pushes its results as one bundle into
// a two-entry queue; the back end sends one result per cycle while
// result_ready is high. With the back end idle, the first result of a
// byte goes through a queue slot into the back end's holding register.
// Throughput: one byte per cycle while each byte yields at most one result
// and result_ready is high; a byte with N results holds the back end
// until all N are sent; the front end stalls only when the queue is full.
// A stalled receiver holds the current result steady; the queue absorbs two
// more bundles, then item_ready drops.
// Reset clears the lexer state (outside any tag, no held byte, counters at
// zero) and empties the queue. end_of_text also returns the state to this.
// Depends on tdl_pkg, tdl_front, tdl_queue, tdl_back.
module template_delimiter_lexer
    import tdl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [7:0]            byte_value,
    input  logic                  end_of_text,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [2:0]            kind,
    output logic [7:0]            out_byte,
    output logic [LINE_OUT_W-1:0] line_number,
    output logic [LEN_OUT_W-1:0]  token_length,
    output logic                  last_of_run
);

    tdl_push_t   push;
    tdl_qstat_t  qstat;
    tdl_bundle_t head;
    logic        pop;

    tdl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .byte_value  (byte_value),
        .end_of_text (end_of_text),
        .qstat       (qstat),
        .push        (push)
    );

    tdl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    tdl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .line_number  (line_number),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

/* hw/rtl/tdl_checker.sv */
// Port-level checks for the template delimiter lexer, bound to the top level.
// Depends on tdl_pkg.
module tdl_checker
    import tdl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [2:0]            kind,
    input logic [7:0]            out_byte,
    input logic [LINE_OUT_W-1:0] line_number,
    input logic [LEN_OUT_W-1:0]  token_length,
    input logic                  last_of_run
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(kind) && $stable(out_byte) &&
            $stable(line_number) && $stable(token_length) && $stable(last_of_run))
        else $error("result payload changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != K_CBYTE && kind != K_IBYTE |-> out_byte == 8'd0)
        else $error("non-byte token carries a byte");

    a_len_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != K_CEND && kind != K_IEND |-> token_length == '0)
        else $error("length on a token that ends nothing");

    a_end_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == K_CEND || kind == K_IEND) |-> token_length != '0)
        else $error("empty token ended");

endmodule

bind template_delimiter_lexer tdl_checker u_tdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .line_number  (line_number),
    .token_length (token_length),
    .last_of_run  (last_of_run)
);

/* verif/tb.sv */
// Self-checking testbench for template_delimiter_lexer: a queue-fed driver, a token predictor
// and a monitor that checks every result beat in order.
// Depends on tdl_pkg and the template_delimiter_lexer RTL.
module tb
    import tdl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_MAX     = (1 << LEN_OUT_W) - 1;
    localparam int RAND_BEATS  = 400;
    localparam int LONG_RUN    = 24;
    localparam int PRESSURE_AT = 150;
    localparam int HOLD_OFF    = 300;
    localparam int DRAIN       = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_beat_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            data;
        logic [LINE_OUT_W-1:0] line;
        logic [LEN_OUT_W-1:0]  length;
        logic                  last;
    } token_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    logic [7:0]            byte_value = '0;
    logic                  end_of_text = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [2:0]            kind;
    logic [7:0]            out_byte;
    logic [LINE_OUT_W-1:0] line_number;
    logic [LEN_OUT_W-1:0]  token_length;
    logic                  last_of_run;

    template_delimiter_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .byte_value   (byte_value),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .line_number  (line_number),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    text_beat_t text_q[$];
    logic [7:0] text_buf[$];
    token_t     token_q[$];
    token_t     staged[MAX_RESULTS];
    int         n_staged;

    logic [1:0]             lx_mode;
    logic [7:0]             la_byte;
    logic                   la_valid;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [LENGTH_BITS-1:0] tok_len;

    int         beats_total;
    int         beats_sent;
    int         rand_beats;
    int         results_seen;
    int         errors;
    int         send_gap;
    int         stall_left;
    int         hold_left;
    int         idle_cycles;
    bit         pressure_done;
    text_beat_t next_beat;
    token_t     want_tok;

    // ---------------- token predictor ----------------

    function automatic void clear_lexer();
        lx_mode  = MODE_OUTSIDE;
        la_byte  = '0;
        la_valid = 1'b0;
        line_cnt = '0;
        tok_len  = '0;
    endfunction

    function automatic bit in_tag();
        return lx_mode == MODE_EXPR || lx_mode == MODE_BLOCK;
    endfunction

    function automatic void stage(input logic [2:0] k, input logic [7:0] d,
                                  input logic [LENGTH_BITS-1:0] len);
        token_t t;
        t.kind   = k;
        t.data   = d;
        t.line   = line_cnt[LINE_OUT_W-1:0];
        t.length = (32'(len) > LEN_MAX) ? LEN_OUT_W'(LEN_MAX) : LEN_OUT_W'(len);
        t.last   = 1'b0;
        if (n_staged < MAX_RESULTS)
        begin
            staged[n_staged] = t;
        end
        n_staged++;
    endfunction

    function automatic void finish_token(input logic [2:0] k);
        if (tok_len != '0)
        begin
            stage(k, 8'h00, tok_len);
        end
        tok_len = '0;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (in_tag())
        begin
            if (b == CH_SPACE)
            begin
                finish_token(K_IEND);
            end
            else
            begin
                if (tok_len != '1)
                begin
                    tok_len++;
                end
                stage(K_IBYTE, b, '0);
            end
        end
        else
        begin
            // newline is counted before its own content beat
            if (b == CH_NEWLINE)
            begin
                line_cnt++;
            end
            if (tok_len != '1)
            begin
                tok_len++;
            end
            stage(K_CBYTE, b, '0);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] b, input logic eot);
        n_staged = 0;
        if (!la_valid)
        begin
            la_byte  = b;
            la_valid = 1'b1;
        end
        else if (!in_tag())
        begin
            if (la_byte == CH_LBRACE && (b == CH_LBRACE || b == CH_PERCENT))
            begin
                finish_token(K_CEND);
                stage((b == CH_LBRACE) ? K_EOPEN : K_BOPEN, 8'h00, '0);
                lx_mode  = (b == CH_LBRACE) ? MODE_EXPR : MODE_BLOCK;
                la_valid = 1'b0;
                la_byte  = '0;
            end
            else
            begin
                plain_byte(la_byte);
                la_byte = b;
            end
        end
        else
        begin
            // close kind follows the first closer byte, not the open kind
            if ((la_byte == CH_RBRACE || la_byte == CH_PERCENT) && b == CH_RBRACE)
            begin
                finish_token(K_IEND);
                stage((la_byte == CH_RBRACE) ? K_ECLOSE : K_BCLOSE, 8'h00, '0);
                lx_mode  = MODE_OUTSIDE;
                la_valid = 1'b0;
                la_byte  = '0;
            end
            else
            begin
                plain_byte(la_byte);
                la_byte = b;
            end
        end
        if (eot)
        begin
            if (la_valid)
            begin
                plain_byte(la_byte);
            end
            if (in_tag())
            begin
                finish_token(K_IEND);
                stage(K_BCLOSE, 8'h00, '0);
            end
            else
            begin
                finish_token(K_CEND);
            end
            clear_lexer();
        end
        if (n_staged > MAX_RESULTS)
        begin
            n_staged = MAX_RESULTS;
        end
        if (n_staged > 0)
        begin
            staged[n_staged-1].last = 1'b1;
        end
        for (int i = 0; i < n_staged; i++)
        begin
            token_q.push_back(staged[i]);
        end
    endfunction

    // ---------------- text generation ----------------

    function automatic void put(input logic [7:0] c);
        text_buf.push_back(c);
    endfunction

    // mark the final byte of the text and hand it to the driver
    function automatic int flush_text();
        text_beat_t tb_beat;
        int         n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            tb_beat.data = text_buf[i];
            tb_beat.eot  = (i == n - 1);
            text_q.push_back(tb_beat);
        end
        text_buf.delete();
        return n;
    endfunction

    function automatic logic [7:0] pick_char(input bit content);
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 8'(8'h61 + $urandom_range(0, 25));
        if (r < 14)
            return 8'(8'h30 + $urandom_range(0, 9));
        if (content)
        begin
            if (r < 16)
                return CH_NEWLINE;
            if (r < 17)
                return CH_SPACE;
            if (r < 18)
                return CH_RBRACE;
            if (r < 19)
                return CH_PERCENT;
        end
        else
        begin
            if (r < 16)
                return "_";
            if (r < 17)
                return CH_NEWLINE;
            if (r < 18)
                return ".";
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_tag(input bit block, input bit open_end);
        int  n_words;
        bit  mismatch;
        put(CH_LBRACE);
        put(block ? CH_PERCENT : CH_LBRACE);
        if ($urandom_range(0, 1))
            put(CH_SPACE);
        n_words = $urandom_range(1, 3);
        for (int w = 0; w < n_words; w++)
        begin
            for (int c = $urandom_range(1, 6); c > 0; c--)
                put(pick_char(1'b0));
            if (w < n_words - 1 || $urandom_range(0, 1))
            begin
                for (int s = $urandom_range(1, 2); s > 0; s--)
                    put(CH_SPACE);
            end
        end
        if (!open_end)
        begin
            mismatch = ($urandom_range(0, 99) < 15);
            put((block ^ mismatch) ? CH_PERCENT : CH_RBRACE);
            put(CH_RBRACE);
        end
    endfunction

    function automatic void gen_text();
        int nseg;
        int sel;
        nseg = $urandom_range(1, 6);
        for (int s = 0; s < nseg; s++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 7)
            begin
                for (int c = $urandom_range(1, 10); c > 0; c--)
                    put(pick_char(1'b1));
            end
            else if (sel < 11)
                add_tag(1'b0, 1'b0);
            else if (sel < 15)
                add_tag(1'b1, 1'b0);
            else if (sel < 17)
            begin
                for (int c = $urandom_range(1, 4); c > 0; c--)
                    put(8'($urandom_range(0, 255)));
            end
            else if (sel < 18)
                put(CH_LBRACE);
            else if (sel < 19)
            begin
                put(CH_PERCENT);
                put(CH_RBRACE);
            end
            else
            begin
                // leave the tag open at end of text
                add_tag($urandom_range(0, 1), 1'b1);
                break;
            end
        end
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- clock, stimulus, end of run ----------------

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        errors     = 0;
        beats_sent = 0;
        rand_beats = 0;

        // content with extreme bytes, newline, lone brace, expression open
        put(8'h00); put(8'hFF); put(CH_NEWLINE); put(CH_LBRACE); put("x");
        put(CH_LBRACE); put(CH_LBRACE);
        // identifiers, newline inside a tag, block closer on an expression tag
        put("a"); put(CH_SPACE); put("b"); put(CH_NEWLINE);
        put(CH_PERCENT); put(CH_RBRACE);
        // block open closed as an expression, then a held byte at end of text
        put(CH_LBRACE); put(CH_PERCENT); put("z"); put(CH_RBRACE); put(CH_RBRACE);
        put("q");
        void'(flush_text());
        put(CH_LBRACE);
        void'(flush_text());
        put(CH_LBRACE); put(CH_PERCENT); put("k");
        void'(flush_text());
        put(CH_LBRACE); put(CH_LBRACE);
        void'(flush_text());

        while (rand_beats < RAND_BEATS)
        begin
            gen_text();
            rand_beats += flush_text();
        end

        // long content run of newlines
        for (int i = 0; i < LONG_RUN; i++)
            put(CH_NEWLINE);
        void'(flush_text());
        // long identifier inside a tag
        put(CH_LBRACE); put(CH_LBRACE);
        for (int i = 0; i < LONG_RUN; i++)
            put("a");
        put(CH_RBRACE); put(CH_RBRACE);
        void'(flush_text());

        beats_total = text_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_sent < beats_total)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (token_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("template_delimiter_lexer verification clean");
        else
            $display("template_delimiter_lexer verification failed");
        $finish;
    end

    // watchdog: end the run after a long stretch with no beat on either side
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("template_delimiter_lexer verification failed");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            byte_value  <= '0;
            end_of_text <= 1'b0;
            send_gap = 0;
            clear_lexer();
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                lex_byte(byte_value, end_of_text);
                beats_sent++;
            end
            // advance only when the slot is empty or its beat was taken
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    next_beat = text_q.pop_front();
                    byte_value  <= next_beat.data;
                    end_of_text <= next_beat.eot;
                    item_valid  <= 1'b1;
                    send_gap = pick_gap((beats_sent % 256) < 48);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left    = 0;
            hold_left     = 0;
            results_seen  = 0;
            pressure_done = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (token_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: unexpected result: kind=%0d byte=%02h",
                                  " line=%0d len=%0d last=%0b"},
                                 $time, kind, out_byte, line_number, token_length,
                                 last_of_run);
                end
                else
                begin
                    want_tok = token_q.pop_front();
                    if (want_tok.kind !== kind || want_tok.data !== out_byte ||
                        want_tok.line !== line_number || want_tok.length !== token_length ||
                        want_tok.last !== last_of_run)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected kind=%0d byte=%02h line=%0d len=%0d",
                                      " last=%0b, got kind=%0d byte=%02h line=%0d len=%0d last=%0b"},
                                     $time, want_tok.kind, want_tok.data, want_tok.line,
                                     want_tok.length, want_tok.last, kind, out_byte,
                                     line_number, token_length, last_of_run);
                    end
                end
            end

            // hold off once for a long stretch so the block fills and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_OFF - 1;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap((results_seen % 200) < 40);
                if (stall_left == 0)
                begin
                    result_ready <= 1'b1;
                end
                else
                begin
                    stall_left--;
                    result_ready <= 1'b0;
                end
            end
        end
    end

endmodule
